// File: rtl/core/smp_pkg.sv
`default_nettype none

package smp_pkg;

  localparam int unsigned MaxOrder    = 4;
  localparam int unsigned ElemWidth   = 32;
  localparam int unsigned MaxExponent = 255;
  localparam int unsigned OrderWidth  = 3;
  localparam int unsigned ExpWidth    = 8;
  localparam int unsigned OrderReset  = 4;

  typedef logic [ElemWidth-1:0] elem_t;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StMul   = 5'b00010,
    StDrain = 5'b00100,
    StRead  = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  // control that rides along with one multiply-accumulate step
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/smp_store.sv
`default_nettype none

module smp_store #(
  parameter int unsigned MAX_ORDER = smp_pkg::MaxOrder,
  localparam int unsigned Cells = MAX_ORDER * MAX_ORDER,
  localparam int unsigned CW = (Cells > 1) ? $clog2(Cells) : 1,
  localparam int unsigned ProdDepth = 2 ** (CW + 1)
) (
  input  wire                 clk_i,
  input  wire                 src_we_i,
  input  wire [CW-1:0]        src_waddr_i,
  input  smp_pkg::elem_t      src_wdata_i,
  input  wire [CW-1:0]        src_raddr_i,
  output smp_pkg::elem_t      src_rdata_o,
  input  wire                 prod_we_i,
  input  wire [CW:0]          prod_waddr_i,
  input  smp_pkg::elem_t      prod_wdata_i,
  input  wire [CW:0]          prod_raddr_i,
  output smp_pkg::elem_t      prod_rdata_o
);

  smp_pkg::elem_t src_mem  [Cells];
  smp_pkg::elem_t prod_mem [ProdDepth];
  smp_pkg::elem_t src_rdata_q;
  smp_pkg::elem_t prod_rdata_q;

  always_ff @(posedge clk_i) begin
    if (src_we_i) begin
      src_mem[src_waddr_i] <= src_wdata_i;
    end
    src_rdata_q <= src_mem[src_raddr_i];
  end

  // two banks: running product and the one being formed
  always_ff @(posedge clk_i) begin
    if (prod_we_i) begin
      prod_mem[prod_waddr_i] <= prod_wdata_i;
    end
    prod_rdata_q <= prod_mem[prod_raddr_i];
  end

  assign src_rdata_o  = src_rdata_q;
  assign prod_rdata_o = prod_rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/smp_mac.sv
`default_nettype none

module smp_mac #(
  parameter int unsigned MAX_ORDER = smp_pkg::MaxOrder,
  localparam int unsigned Cells = MAX_ORDER * MAX_ORDER,
  localparam int unsigned CW = (Cells > 1) ? $clog2(Cells) : 1
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  smp_pkg::mac_ctl_t   ctl_i,
  input  wire [CW-1:0]        dest_i,
  input  smp_pkg::elem_t      a_i,
  input  smp_pkg::elem_t      b_i,
  output logic                wr_en_o,
  output logic [CW-1:0]       wr_addr_o,
  output smp_pkg::elem_t      wr_data_o
);

  smp_pkg::mac_ctl_t ctl1_q, ctl2_q;
  logic [CW-1:0]     dest1_q, dest2_q;
  smp_pkg::elem_t    prod_q;
  smp_pkg::elem_t    acc_q, acc_d;

  // stage 1 lines up with registered read data, stage 2 holds the product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dest1_q <= dest_i;
    dest2_q <= dest1_q;
    prod_q  <= a_i * b_i;
    acc_q   <= acc_d;
  end

  always_comb begin
    if (ctl2_q.first) begin
      acc_d = prod_q;
    end else begin
      acc_d = acc_q + prod_q;
    end
  end

  assign wr_en_o   = ctl2_q.valid & ctl2_q.last;
  assign wr_addr_o = dest2_q;
  assign wr_data_o = acc_d;

endmodule

`default_nettype wire

// File: rtl/core/square_matrix_power.sv
// load: one element beat per cycle while idle and no order write is pending, n*n beats, n
// being the order clamped to 1..MAX_ORDER; the last beat carries the exponent; compute:
// exponent-1 matrix multiplies through one 32x32 multiply-accumulate, each then a drain
// output: n*n result beats, each a memory read, then a hold until taken; reset: order returns
// to 4, load position and sequencer clear; element stores are undefined until loaded
`default_nettype none

module square_matrix_power #(
  parameter int unsigned MAX_ORDER    = smp_pkg::MaxOrder,
  parameter int unsigned MAX_EXPONENT = smp_pkg::MaxExponent
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire [smp_pkg::OrderWidth-1:0]       cfg_wdata_i,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire signed [smp_pkg::ElemWidth-1:0] element_i,
  input  wire [smp_pkg::ExpWidth-1:0]         exponent_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic signed [smp_pkg::ElemWidth-1:0] value_o,
  output logic                                last_o
);

  localparam int unsigned Cells = MAX_ORDER * MAX_ORDER;
  localparam int unsigned CW = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int unsigned IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int unsigned EW = (MAX_EXPONENT > 1) ? $clog2(MAX_EXPONENT + 1) : 1;
  localparam logic [1:0] DrainLast = 2'd2;

  smp_pkg::state_e state_q, state_d;
  logic [smp_pkg::OrderWidth-1:0] order_q;
  logic [IW-1:0] r_q, r_d, c_q, c_d, k_q, k_d;
  logic [EW-1:0] steps_q, steps_d;
  logic [1:0]    drain_q, drain_d;
  logic          bank_q, bank_d;
  logic          ident_q, ident_d;

  logic [31:0]   n32;
  logic [IW-1:0] nm1;
  logic [EW-1:0] exp_sat;
  logic          last_rc;
  logic          load_we;

  smp_pkg::mac_ctl_t mac_ctl;
  logic              mac_wr_en;
  logic [CW-1:0]     mac_wr_addr;
  smp_pkg::elem_t    mac_wr_data;
  smp_pkg::elem_t    src_rdata, prod_rdata;
  logic [CW-1:0]     idx_rc, idx_rk, idx_kc;
  logic [CW:0]       prod_raddr, prod_waddr;
  smp_pkg::elem_t    out_data;

  function automatic logic [CW-1:0] cell_idx(logic [IW-1:0] row, logic [IW-1:0] col,
                                             logic [31:0] n);
    logic [31:0] sum;
    sum = 32'(row) * n + 32'(col);
    return sum[CW-1:0];
  endfunction

  always_comb begin
    if (order_q == '0) begin
      n32 = 32'd1;
    end else if (32'(order_q) > MAX_ORDER) begin
      n32 = 32'(MAX_ORDER);
    end else begin
      n32 = 32'(order_q);
    end
  end

  assign nm1     = IW'(n32 - 32'd1);
  assign exp_sat = (32'(exponent_i) > MAX_EXPONENT) ? EW'(MAX_EXPONENT) : EW'(exponent_i);
  assign last_rc = (r_q == nm1) && (c_q == nm1);
  assign idx_rc  = cell_idx(r_q, c_q, n32);
  assign idx_rk  = cell_idx(r_q, k_q, n32);
  assign idx_kc  = cell_idx(k_q, c_q, n32);

  always_comb begin
    state_d = state_q;
    r_d = r_q;
    c_d = c_q;
    k_d = k_q;
    steps_d = steps_q;
    drain_d = drain_q;
    bank_d = bank_q;
    ident_d = ident_q;
    load_we = 1'b0;
    mac_ctl = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      smp_pkg::StIdle: begin
        in_ready_o = !cfg_we_i;
        if (cfg_we_i) begin
          r_d = '0;
          c_d = '0;
        end else if (in_valid_i) begin
          load_we = 1'b1;
          if (c_q == nm1) begin
            c_d = '0;
            r_d = r_q + 1'b1;
          end else begin
            c_d = c_q + 1'b1;
          end
          if (last_rc) begin
            r_d = '0;
            c_d = '0;
            k_d = '0;
            if (exp_sat == '0) begin
              ident_d = 1'b1;
              state_d = smp_pkg::StRead;
            end else begin
              ident_d = 1'b0;
              steps_d = exp_sat - 1'b1;
              state_d = (exp_sat == EW'(1)) ? smp_pkg::StRead : smp_pkg::StMul;
            end
          end
        end
      end
      smp_pkg::StMul: begin
        mac_ctl.valid = 1'b1;
        mac_ctl.first = (k_q == '0);
        mac_ctl.last  = (k_q == nm1);
        if (k_q == nm1) begin
          k_d = '0;
          if (c_q == nm1) begin
            c_d = '0;
            if (r_q == nm1) begin
              r_d = '0;
              drain_d = '0;
              state_d = smp_pkg::StDrain;
            end else begin
              r_d = r_q + 1'b1;
            end
          end else begin
            c_d = c_q + 1'b1;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      smp_pkg::StDrain: begin
        drain_d = drain_q + 1'b1;
        if (drain_q == DrainLast) begin
          bank_d  = ~bank_q;
          steps_d = steps_q - 1'b1;
          state_d = (steps_q == EW'(1)) ? smp_pkg::StRead : smp_pkg::StMul;
        end
      end
      smp_pkg::StRead: begin
        state_d = smp_pkg::StOut;
      end
      smp_pkg::StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (last_rc) begin
            r_d = '0;
            c_d = '0;
            state_d = smp_pkg::StIdle;
          end else begin
            if (c_q == nm1) begin
              c_d = '0;
              r_d = r_q + 1'b1;
            end else begin
              c_d = c_q + 1'b1;
            end
            state_d = smp_pkg::StRead;
          end
        end
      end
      default: begin
        state_d = smp_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smp_pkg::StIdle;
      order_q <= smp_pkg::OrderWidth'(smp_pkg::OrderReset);
      r_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
      steps_q <= '0;
      drain_q <= '0;
      bank_q  <= 1'b0;
      ident_q <= 1'b0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
      k_q     <= k_d;
      steps_q <= steps_d;
      drain_q <= drain_d;
      bank_q  <= bank_d;
      ident_q <= ident_d;
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
    end
  end

  // running product is read from bank_q, the new product goes to the other bank
  assign prod_raddr = (state_q == smp_pkg::StMul) ? {bank_q, idx_rk} : {bank_q, idx_rc};
  assign prod_waddr = mac_wr_en ? {~bank_q, mac_wr_addr} : {bank_q, idx_rc};

  smp_store #(
    .MAX_ORDER(MAX_ORDER)
  ) u_store (
    .clk_i        (clk_i),
    .src_we_i     (load_we),
    .src_waddr_i  (idx_rc),
    .src_wdata_i  (unsigned'(element_i)),
    .src_raddr_i  (idx_kc),
    .src_rdata_o  (src_rdata),
    .prod_we_i    (load_we | mac_wr_en),
    .prod_waddr_i (prod_waddr),
    .prod_wdata_i (mac_wr_en ? mac_wr_data : unsigned'(element_i)),
    .prod_raddr_i (prod_raddr),
    .prod_rdata_o (prod_rdata)
  );

  smp_mac #(
    .MAX_ORDER(MAX_ORDER)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mac_ctl),
    .dest_i    (idx_rc),
    .a_i       (prod_rdata),
    .b_i       (src_rdata),
    .wr_en_o   (mac_wr_en),
    .wr_addr_o (mac_wr_addr),
    .wr_data_o (mac_wr_data)
  );

  assign out_data = ident_q ? {{(smp_pkg::ElemWidth-1){1'b0}}, (r_q == c_q)} : prod_rdata;
  assign value_o  = signed'(out_data);
  assign last_o   = last_rc;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output beats overlap");

  a_mac_write_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_wr_en |-> (state_q == smp_pkg::StMul || state_q == smp_pkg::StDrain))
    else $error("product write outside multiply");

  a_steps_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == smp_pkg::StMul || state_q == smp_pkg::StDrain) |-> (steps_q != '0))
    else $error("multiply with no step left");

  a_bank_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == smp_pkg::StMul) |=> $stable(bank_q))
    else $error("bank swapped during multiply");

endmodule

`default_nettype wire

// File: tb/square_matrix_power_tb.sv
`default_nettype none

module square_matrix_power_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import smp_pkg::*;

  localparam int ItemTarget   = 220;
  localparam int SettleCycles = 8;
  localparam int LongHold     = 400;
  localparam int StallLimit   = 100000;
  localparam int Cells        = MaxOrder * MaxOrder;

  typedef struct packed {
    elem_t value;
    logic  last;
  } power_beat_t;

  typedef struct packed {
    bit                    wr_cfg;
    logic [OrderWidth-1:0] cfg;
    elem_t                 elem;
    logic [ExpWidth-1:0]   power;
    bit                    typed;
    elem_t                 typed_val;
  } dir_row_t;

  // order 1 and order 0 rows carry their single result, the rest go through the predictor
  localparam dir_row_t DirRows [18] = '{
    '{1'b1, 3'd1, 32'd5,         8'd0,   1'b1, 32'd1},
    '{1'b0, 3'd0, 32'h7fff_ffff, 8'd1,   1'b1, 32'h7fff_ffff},
    '{1'b0, 3'd0, 32'h8000_0000, 8'd1,   1'b1, 32'h8000_0000},
    '{1'b0, 3'd0, 32'h8000_0000, 8'd2,   1'b1, 32'd0},
    '{1'b0, 3'd0, 32'hffff_ffff, 8'd255, 1'b1, 32'hffff_ffff},
    '{1'b0, 3'd0, 32'd3,         8'd2,   1'b1, 32'd9},
    '{1'b1, 3'd0, 32'd7,         8'd3,   1'b1, 32'd343},
    '{1'b0, 3'd0, 32'd0,         8'd0,   1'b1, 32'd1},
    // partial load, then the order write restarts it
    '{1'b1, 3'd2, 32'd1,         8'haa,  1'b0, 32'd0},
    '{1'b0, 3'd0, 32'd2,         8'h55,  1'b0, 32'd0},
    '{1'b1, 3'd2, 32'h7fff_ffff, 8'd0,   1'b0, 32'd0},
    '{1'b0, 3'd0, 32'h8000_0000, 8'd0,   1'b0, 32'd0},
    '{1'b0, 3'd0, 32'd0,         8'd0,   1'b0, 32'd0},
    '{1'b0, 3'd0, 32'hffff_ffff, 8'd0,   1'b0, 32'd0},
    '{1'b0, 3'd0, 32'd1,         8'd0,   1'b0, 32'd0},
    '{1'b0, 3'd0, 32'd1,         8'd0,   1'b0, 32'd0},
    '{1'b0, 3'd0, 32'd1,         8'd0,   1'b0, 32'd0},
    '{1'b0, 3'd0, 32'd0,         8'd255, 1'b0, 32'd0}
  };

  localparam logic [OrderWidth-1:0] OrderPlan [8] = '{
    3'd4, 3'd3, 3'd7, 3'd2, 3'd5, 3'd1, 3'd0, 3'd6
  };

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [OrderWidth-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  elem_t                 element_i   = '0;
  logic [ExpWidth-1:0]   exponent_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic signed [ElemWidth-1:0] value_o;
  logic                  last_o;

  square_matrix_power u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .element_i   (element_i),
    .exponent_i  (exponent_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .last_o      (last_o)
  );

  // predictor state
  logic [OrderWidth-1:0] order_shadow = OrderReset;
  elem_t                 src_mat [Cells];
  elem_t                 pow_mat [Cells];
  int                    load_pos = 0;
  power_beat_t           pending_beats [$];

  int       mismatches    = 0;
  int       elems_sent    = 0;
  int       beats_taken   = 0;
  int       matrices_done = 0;
  int       long_holds    = 0;
  bit [7:0] orders_seen   = '0;
  bit       sender_lazy   = 1'b0;
  bit       stall_request = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int dim_of(input logic [OrderWidth-1:0] o);
    if (o == 0) return 1;
    if (o > MaxOrder) return MaxOrder;
    return int'(o);
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // stores one element; on the last one forms the power and queues its beats
  task automatic absorb_element(input elem_t elem, input logic [ExpWidth-1:0] power);
    int    n;
    elem_t acc;
    elem_t nxt [Cells];
    n = dim_of(order_shadow);
    src_mat[load_pos] = elem;
    load_pos++;
    if (load_pos < n * n) return;
    load_pos = 0;
    for (int i = 0; i < n * n; i++)
      pow_mat[i] = (power == 0) ? elem_t'(i / n == i % n) : src_mat[i];
    for (int s = 1; s < int'(power); s++) begin
      for (int r = 0; r < n; r++) begin
        for (int c = 0; c < n; c++) begin
          acc = '0;
          for (int k = 0; k < n; k++) acc += pow_mat[r * n + k] * src_mat[k * n + c];
          nxt[r * n + c] = acc;
        end
      end
      for (int i = 0; i < n * n; i++) pow_mat[i] = nxt[i];
    end
    for (int i = 0; i < n * n; i++)
      pending_beats.push_back('{value: pow_mat[i], last: (i == n * n - 1)});
    matrices_done++;
  endtask

  task automatic send_element(input elem_t elem, input logic [ExpWidth-1:0] power);
    int gap;
    gap = sender_lazy ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    element_i  <= elem;
    exponent_i <= power;
    do @(posedge clk_i); while (!in_ready_o);
    elems_sent++;
    absorb_element(elem, power);
  endtask

  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_beats.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_order(input logic [OrderWidth-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    order_shadow = value;
    load_pos     = 0;
    orders_seen[value] = 1'b1;
  endtask

  function automatic elem_t pick_element();
    elem_t v;
    case ($urandom_range(0, 7))
      0, 1, 2: v = $urandom;
      3: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7fff_ffff;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      default: v = elem_t'($urandom_range(0, 8) - 4);
    endcase
    return v;
  endfunction

  function automatic logic [ExpWidth-1:0] pick_power();
    logic [ExpWidth-1:0] p;
    case ($urandom_range(0, 15))
      0:       p = 8'($urandom_range(0, 255));
      1:       p = '0;
      2:       p = 8'd1;
      default: p = 8'($urandom_range(2, 6));
    endcase
    return p;
  endfunction

  initial begin : stimulus
    dir_row_t              row;
    power_beat_t           beat;
    int                    n;
    int                    count;
    int                    cut;
    logic [OrderWidth-1:0] phase_order;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[i]) begin
      row = DirRows[i];
      if (row.wr_cfg) begin
        drain_and_settle();
        write_order(row.cfg);
      end
      send_element(row.elem, row.power);
      if (row.typed) begin
        beat = pending_beats.pop_back();
        beat.value = row.typed_val;
        pending_beats.push_back(beat);
      end
    end

    for (int phase = 0; elems_sent < ItemTarget; phase++) begin
      phase_order = (phase < 8) ? OrderPlan[phase] : 3'($urandom_range(0, 7));
      drain_and_settle();
      write_order(phase_order);
      n = dim_of(phase_order);
      count = (n == 1) ? $urandom_range(4, 10) : $urandom_range(2, 3);
      // output side stalls for LongHold, which holds off the push of the next matrix
      if (phase == 1) stall_request = 1'b1;
      for (int m = 0; m < count; m++) begin
        sender_lazy = ($urandom_range(0, 2) != 0);
        if (phase != 1 && n > 1 && $urandom_range(0, 5) == 0) begin
          cut = $urandom_range(1, n * n - 1);
          repeat (cut) send_element(pick_element(), 8'($urandom));
          drain_and_settle();
          write_order(phase_order);
        end
        for (int e = 0; e < n * n; e++)
          send_element(pick_element(), (e == n * n - 1) ? pick_power() : 8'($urandom));
      end
    end

    drain_and_settle();
    repeat (50) @(posedge clk_i);
    $display("covered %0d element beats and %0d result beats over %0d matrices",
             elems_sent, beats_taken, matrices_done);
    $display("order values written %b, long output stalls %0d, mismatches %0d",
             orders_seen, long_holds, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    int          hold;
    bit          lazy;
    power_beat_t want;
    lazy = 1'b0;
    forever begin
      if (beats_taken % 16 == 0) lazy = ($urandom_range(0, 1) != 0);
      hold = lazy ? $urandom_range(0, 5) : 0;
      if (stall_request) begin
        hold = LongHold;
        stall_request = 1'b0;
        long_holds++;
      end
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      beats_taken++;
      if (pending_beats.size() == 0) begin
        flag_mismatch($sformatf("unexpected result beat value %h last %b", value_o, last_o));
      end else begin
        want = pending_beats.pop_front();
        if (value_o !== want.value)
          flag_mismatch($sformatf("value got %h want %h", value_o, want.value));
        if (last_o !== want.last)
          flag_mismatch($sformatf("last got %b want %b", last_o, want.last));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("no beat moved for %0d cycles, %0d results outstanding",
             StallLimit, pending_beats.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
